// File: sv/c2p_pkg.sv
package c2p_pkg;

  // geometry of the destination planes
  localparam int PLANE_PITCH = 80;
  localparam int MAX_ROWS    = 350;
  localparam int MAX_COLUMNS = 640;

  // field and register widths
  localparam int WIDTH_W   = 10;
  localparam int HEIGHT_W  = 9;
  localparam int STRIDE_W  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int COL_W     = 16;
  localparam int ROW_W     = 9;
  localparam int OFFSET_W  = 15;
  localparam int PLANES    = 4;

  // row counter sticks here instead of wrapping
  localparam logic [ROW_W-1:0] ROW_SAT = '1;

  // running row * pitch, wide enough for the saturated row
  localparam int ROW_BASE_W = $clog2(int'(ROW_SAT) * PLANE_PITCH + 1);

  // reset values of the configuration registers
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 10'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 9'd350;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd640;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ACTIVE_WIDTH  = 2'd0,
    REG_ACTIVE_HEIGHT = 2'd1,
    REG_SOURCE_STRIDE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    FUNC_PIXEL       = 1'b0,
    FUNC_FRAME_START = 1'b1
  } func_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  active_width;
    logic [HEIGHT_W-1:0] active_height;
    logic [STRIDE_W-1:0] source_stride;
  } cfg_t;

endpackage

// File: sv/c2p_in_if.sv
interface c2p_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] pixel_byte;

  modport source (output valid, output func, output pixel_byte, input ready);
  modport sink (input valid, input func, input pixel_byte, output ready);
endinterface

// File: sv/c2p_out_if.sv
interface c2p_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    plane_zero_byte;
  logic [7:0]                    plane_one_byte;
  logic [7:0]                    plane_two_byte;
  logic [7:0]                    plane_three_byte;
  logic [c2p_pkg::OFFSET_W-1:0]  plane_offset;

  modport source (
    output valid, output plane_zero_byte, output plane_one_byte,
    output plane_two_byte, output plane_three_byte, output plane_offset,
    input ready
  );
  modport sink (
    input valid, input plane_zero_byte, input plane_one_byte,
    input plane_two_byte, input plane_three_byte, input plane_offset,
    output ready
  );
endinterface

// File: sv/c2p_cfg.sv
module c2p_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [c2p_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [c2p_pkg::CFG_DATA_W-1:0]    cfg_data,
  output c2p_pkg::cfg_t                     cfg
);

  logic [c2p_pkg::WIDTH_W-1:0]  width_in;
  logic [c2p_pkg::HEIGHT_W-1:0] height_in;
  logic [c2p_pkg::WIDTH_W-1:0]  width_sat;
  logic [c2p_pkg::HEIGHT_W-1:0] height_sat;

  assign width_in  = cfg_data[c2p_pkg::WIDTH_W-1:0];
  assign height_in = cfg_data[c2p_pkg::HEIGHT_W-1:0];

  // saturate on write
  always_comb begin
    if (int'(width_in) > c2p_pkg::MAX_COLUMNS) begin
      width_sat = c2p_pkg::WIDTH_W'(c2p_pkg::MAX_COLUMNS);
    end else begin
      width_sat = width_in;
    end
    if (int'(height_in) > c2p_pkg::MAX_ROWS) begin
      height_sat = c2p_pkg::HEIGHT_W'(c2p_pkg::MAX_ROWS);
    end else begin
      height_sat = height_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_width  <= c2p_pkg::WIDTH_RESET;
      cfg.active_height <= c2p_pkg::HEIGHT_RESET;
      cfg.source_stride <= c2p_pkg::STRIDE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        c2p_pkg::REG_ACTIVE_WIDTH:  cfg.active_width  <= width_sat;
        c2p_pkg::REG_ACTIVE_HEIGHT: cfg.active_height <= height_sat;
        c2p_pkg::REG_SOURCE_STRIDE: cfg.source_stride <= cfg_data[c2p_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/chunky_to_planar_blit.sv
// Chunky-to-planar converter for 16-colour images. Source bytes enter on
// pixel_in, one per transfer, in address order; the low nibble of each byte
// is a colour index whose bit p lands in plane p, leftmost pixel in bit 7.
// Every eighth pixel of a row, or the last pixel inside the clipped width,
// produces one transfer on blit_out with the four plane bytes and the byte
// offset row * 80 + column / 8. Pixels outside the clipped width/height are
// consumed and dropped; a frame-start transfer (func = 1) clears the counters.
// Rate: one input transfer per clock, sustained. A result appears in the
// output register the cycle after the transfer that completes it. pixel_in
// stalls only while that output register holds a result not yet taken by
// blit_out. Configuration writes through cfg_write/cfg_index/cfg_data are
// meant for idle periods; width saturates at 640 and height at 350.
module chunky_to_planar_blit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [c2p_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [c2p_pkg::CFG_DATA_W-1:0]    cfg_data,
  c2p_in_if.sink                            pixel_in,
  c2p_out_if.source                         blit_out
);

  localparam int COL_SHIFT_W = c2p_pkg::COL_W - 3;
  localparam int OFF_SUM_W_0 = (c2p_pkg::ROW_BASE_W > COL_SHIFT_W) ?
                               c2p_pkg::ROW_BASE_W : COL_SHIFT_W;
  localparam int OFF_SUM_W   = ((OFF_SUM_W_0 + 1) > c2p_pkg::OFFSET_W) ?
                               (OFF_SUM_W_0 + 1) : c2p_pkg::OFFSET_W;

  c2p_pkg::cfg_t cfg;

  // walking state
  logic [c2p_pkg::COL_W-1:0]      col;
  logic [c2p_pkg::ROW_W-1:0]      row;
  logic [c2p_pkg::ROW_BASE_W-1:0] row_base;   // row * pitch, tracked alongside row
  logic [7:0]                     acc [c2p_pkg::PLANES];

  // output register
  logic                           out_valid;
  logic [7:0]                     out_plane [c2p_pkg::PLANES];
  logic [c2p_pkg::OFFSET_W-1:0]   out_offset;

  // combinational path
  logic                           accept;
  logic                           frame_start;
  logic [c2p_pkg::STRIDE_W:0]     stride_eff;
  logic [c2p_pkg::WIDTH_W-1:0]    width_eff;
  logic                           in_area;
  logic                           last_in_group;
  logic                           emit;
  logic [c2p_pkg::COL_W:0]        col_inc;
  logic                           wrap;
  logic [2:0]                     pos;
  logic [3:0]                     color;
  logic [7:0]                     acc_merged [c2p_pkg::PLANES];
  logic [OFF_SUM_W-1:0]           offset_sum;

  c2p_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // take a new transfer whenever the output register is free or being drained
  assign pixel_in.ready = !out_valid || blit_out.ready;
  assign accept         = pixel_in.valid && pixel_in.ready;
  assign frame_start    = (pixel_in.func == c2p_pkg::FUNC_FRAME_START);
  assign color          = pixel_in.pixel_byte[3:0];

  always_comb begin
    // a zero stride means the column counter wraps at its full range
    if (cfg.source_stride == '0) begin
      stride_eff = {1'b1, {c2p_pkg::STRIDE_W{1'b0}}};
    end else begin
      stride_eff = {1'b0, cfg.source_stride};
    end

    // clip width to the stride; the narrow result fits whenever stride wins
    if ((c2p_pkg::STRIDE_W + 1)'(cfg.active_width) < stride_eff) begin
      width_eff = cfg.active_width;
    end else begin
      width_eff = stride_eff[c2p_pkg::WIDTH_W-1:0];
    end

    in_area = ((c2p_pkg::HEIGHT_W)'(row) < cfg.active_height) &&
              (col < c2p_pkg::COL_W'(width_eff));
    last_in_group = (col[2:0] == 3'd7) ||
                    (col == (c2p_pkg::COL_W'(width_eff) - c2p_pkg::COL_W'(1)));
    emit = in_area && last_in_group;

    // leftmost pixel of the group goes to bit 7
    pos = 3'd7 - col[2:0];
    for (int p = 0; p < c2p_pkg::PLANES; p++) begin
      acc_merged[p] = acc[p] | (8'(color[p]) << pos);
    end

    col_inc = {1'b0, col} + (c2p_pkg::COL_W + 1)'(1);
    wrap    = (c2p_pkg::STRIDE_W + 1)'(col_inc) >= stride_eff;

    offset_sum = OFF_SUM_W'(row_base) + OFF_SUM_W'(col[c2p_pkg::COL_W-1:3]);
  end

  // counters and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      row_base <= '0;
      for (int p = 0; p < c2p_pkg::PLANES; p++) begin
        acc[p] <= '0;
      end
    end else if (accept) begin
      if (frame_start) begin
        col      <= '0;
        row      <= '0;
        row_base <= '0;
        for (int p = 0; p < c2p_pkg::PLANES; p++) begin
          acc[p] <= '0;
        end
      end else begin
        // cleared after every emitted group so partial bytes start at zero
        if (emit) begin
          for (int p = 0; p < c2p_pkg::PLANES; p++) begin
            acc[p] <= '0;
          end
        end else if (in_area) begin
          for (int p = 0; p < c2p_pkg::PLANES; p++) begin
            acc[p] <= acc_merged[p];
          end
        end
        if (wrap) begin
          col <= '0;
          // row sticks at its top value; rows that far down never emit
          if (row != c2p_pkg::ROW_SAT) begin
            row      <= row + c2p_pkg::ROW_W'(1);
            row_base <= row_base + c2p_pkg::ROW_BASE_W'(c2p_pkg::PLANE_PITCH);
          end
        end else begin
          col <= col_inc[c2p_pkg::COL_W-1:0];
        end
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit && !frame_start;
    end else if (blit_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload, loaded only with a fresh result
  always_ff @(posedge clk) begin
    if (accept && emit && !frame_start) begin
      for (int p = 0; p < c2p_pkg::PLANES; p++) begin
        out_plane[p] <= acc_merged[p];
      end
      out_offset <= offset_sum[c2p_pkg::OFFSET_W-1:0];
    end
  end

  assign blit_out.valid            = out_valid;
  assign blit_out.plane_zero_byte  = out_plane[0];
  assign blit_out.plane_one_byte   = out_plane[1];
  assign blit_out.plane_two_byte   = out_plane[2];
  assign blit_out.plane_three_byte = out_plane[3];
  assign blit_out.plane_offset     = out_offset;

  // an emitted group leaves the accumulators empty
  a_acc_cleared_after_emit: assert property (
    @(posedge clk) disable iff (rst)
    (accept && !frame_start && emit) |=>
      (acc[0] == '0 && acc[1] == '0 && acc[2] == '0 && acc[3] == '0)
  ) else $error("accumulators not cleared after emitted group");

  // frame start rewinds every counter
  a_frame_start_rewinds: assert property (
    @(posedge clk) disable iff (rst)
    (accept && frame_start) |=> (col == '0 && row == '0 && row_base == '0)
  ) else $error("counters not cleared by frame start");

  // tracked row base stays equal to row times pitch below saturation
  a_row_base_tracks_row: assert property (
    @(posedge clk) disable iff (rst)
    (row != c2p_pkg::ROW_SAT) |->
      (row_base == c2p_pkg::ROW_BASE_W'(int'(row) * c2p_pkg::PLANE_PITCH))
  ) else $error("row base out of step with row counter");

endmodule

// File: tb/sv/chunky_to_planar_blit_test.sv
module chunky_to_planar_blit_test;

  // run limits
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;
  localparam int RAND_PHASES = 12;
  localparam int LONG_RUN    = 530;

  // one source transfer as the driver holds it
  typedef struct packed {
    c2p_pkg::func_t func;
    logic [7:0]     pixel_byte;
  } pixel_item_t;

  // one planar output word: planes[p] holds bit p of eight pixels
  typedef struct packed {
    logic [c2p_pkg::PLANES-1:0][7:0] planes;
    logic [c2p_pkg::OFFSET_W-1:0]    offset;
  } planar_word_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write;
  logic [c2p_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [c2p_pkg::CFG_DATA_W-1:0]  cfg_data;

  c2p_in_if  pixel_if ();
  c2p_out_if blit_if ();

  chunky_to_planar_blit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pixel_if.sink),
    .blit_out  (blit_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // planar conversion model: geometry registers, counters, accumulators
  // ------------------------------------------------------------------
  logic [c2p_pkg::WIDTH_W-1:0]     width_reg;
  logic [c2p_pkg::HEIGHT_W-1:0]    height_reg;
  logic [c2p_pkg::STRIDE_W-1:0]    stride_reg;
  logic [c2p_pkg::COL_W-1:0]       col_cnt;
  logic [c2p_pkg::ROW_W-1:0]       row_cnt;
  logic [c2p_pkg::PLANES-1:0][7:0] plane_acc;

  // source bytes waiting to be driven, plane words waiting to be seen
  pixel_item_t  pixel_queue[$];
  planar_word_t planar_due[$];

  int unsigned items_pushed;
  int unsigned items_taken;
  int unsigned frame_starts;
  int unsigned words_checked;
  int unsigned geometry_count;
  int unsigned fail_count;
  int unsigned cycles;

  // idling on both channels is enabled per phase
  bit idle_on;
  int send_gap;
  int stall_left;

  planar_word_t seen_word;
  planar_word_t due_word;

  // fold one accepted source transfer into the model, queue any word it closes
  task automatic convert_pixel(input pixel_item_t item);
    int unsigned stride_eff;
    int unsigned width_eff;
    int unsigned col;
    int unsigned row;
    int unsigned bit_pos;
    int p;
    planar_word_t word;
    col = col_cnt;
    row = row_cnt;
    if (item.func == c2p_pkg::FUNC_FRAME_START) begin
      // frame start: counters and accumulators clear, byte ignored
      col_cnt = '0;
      row_cnt = '0;
      plane_acc = '0;
      frame_starts++;
    end else begin
      // stride of zero means the column counter wraps at its full range
      stride_eff = (stride_reg == 0) ? 65536 : stride_reg;
      // width never exceeds the stride
      width_eff = (width_reg < stride_eff) ? width_reg : stride_eff;
      if (row < height_reg && col < width_eff) begin
        // leftmost pixel of a group lands in bit 7; bits left over from a row
        // cut short by a geometry change stay merged in
        bit_pos = 7 - (col % 8);
        for (p = 0; p < c2p_pkg::PLANES; p++)
          plane_acc[p][bit_pos] = plane_acc[p][bit_pos] | item.pixel_byte[p];
        // full group, or last used column closes a partial group
        if (col % 8 == 7 || col == width_eff - 1) begin
          word.planes = plane_acc;
          word.offset = c2p_pkg::OFFSET_W'(row * c2p_pkg::PLANE_PITCH + col / 8);
          planar_due.push_back(word);
          plane_acc = '0;
        end
      end
      // wrap also covers a stride lowered below the current column
      if (col + 1 >= stride_eff) begin
        col_cnt = '0;
        row_cnt = (row_cnt == c2p_pkg::ROW_SAT) ? c2p_pkg::ROW_SAT : row_cnt + 1'b1;
      end else begin
        col_cnt = c2p_pkg::COL_W'(col + 1);
      end
    end
  endtask

  // one register write on the config port, mirrored into the model
  task automatic program_reg(input c2p_pkg::cfg_reg_t idx,
                             input logic [c2p_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      c2p_pkg::REG_ACTIVE_WIDTH: begin
        width_reg = (value[c2p_pkg::WIDTH_W-1:0] > c2p_pkg::MAX_COLUMNS) ?
                    c2p_pkg::WIDTH_W'(c2p_pkg::MAX_COLUMNS) :
                    value[c2p_pkg::WIDTH_W-1:0];
      end
      c2p_pkg::REG_ACTIVE_HEIGHT: begin
        height_reg = (value[c2p_pkg::HEIGHT_W-1:0] > c2p_pkg::MAX_ROWS) ?
                     c2p_pkg::HEIGHT_W'(c2p_pkg::MAX_ROWS) :
                     value[c2p_pkg::HEIGHT_W-1:0];
      end
      c2p_pkg::REG_SOURCE_STRIDE: begin
        stride_reg = value;
      end
      default: begin
      end
    endcase
  endtask

  // rewrite all three geometry registers, back to back
  task automatic set_geometry(input logic [c2p_pkg::CFG_DATA_W-1:0] w_data,
                              input logic [c2p_pkg::CFG_DATA_W-1:0] h_data,
                              input logic [c2p_pkg::CFG_DATA_W-1:0] s_data);
    program_reg(c2p_pkg::REG_ACTIVE_WIDTH, w_data);
    program_reg(c2p_pkg::REG_ACTIVE_HEIGHT, h_data);
    program_reg(c2p_pkg::REG_SOURCE_STRIDE, s_data);
    @(posedge clk);
    cfg_write <= 1'b0;
    geometry_count++;
  endtask

  task automatic push_item(input c2p_pkg::func_t f, input logic [7:0] px);
    pixel_queue.push_back('{f, px});
    items_pushed++;
  endtask

  // block until every pushed byte is taken and every word has come out,
  // then wait on so that a byte that closes no word has also gone through
  task automatic wait_drained();
    while (items_taken != items_pushed || planar_due.size() != 0 || pixel_if.valid)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic log_fail(input string what, input planar_word_t want,
                          input planar_word_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s at cycle %0d: expected %h %h %h %h @%0d, got %h %h %h %h @%0d",
               what, cycles,
               want.planes[0], want.planes[1], want.planes[2], want.planes[3], want.offset,
               got.planes[0], got.planes[1], got.planes[2], got.planes[3], got.offset);
  endtask

  // ------------------------------------------------------------------
  // source driver: one byte per transfer, random gaps between transfers
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pixel_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      // transfer completed at this edge: run it through the model
      if (pixel_if.valid && pixel_if.ready) begin
        convert_pixel('{c2p_pkg::func_t'(pixel_if.func), pixel_if.pixel_byte});
        items_taken++;
      end
      // valid stays up until the byte is taken
      if (!pixel_if.valid || pixel_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pixel_if.valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          pixel_if.valid      <= 1'b1;
          pixel_if.func       <= pixel_queue[0].func;
          pixel_if.pixel_byte <= pixel_queue[0].pixel_byte;
          void'(pixel_queue.pop_front());
          if (idle_on && $urandom_range(0, 99) < 15)
            send_gap = $urandom_range(1, 18);
        end else begin
          pixel_if.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // result monitor: checks each word against the oldest outstanding one,
  // and throttles ready in random bursts
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      blit_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (blit_if.valid && blit_if.ready) begin
        seen_word.planes = {blit_if.plane_three_byte, blit_if.plane_two_byte,
                            blit_if.plane_one_byte, blit_if.plane_zero_byte};
        seen_word.offset = blit_if.plane_offset;
        if (planar_due.size() == 0) begin
          log_fail("word with nothing outstanding", '0, seen_word);
        end else begin
          due_word = planar_due.pop_front();
          words_checked++;
          if (seen_word.planes !== due_word.planes || seen_word.offset !== due_word.offset)
            log_fail("plane word mismatch", due_word, seen_word);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        blit_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 12) begin
        // start a burst of random length with ready held low
        stall_left = $urandom_range(0, 17);
        blit_if.ready <= 1'b0;
      end else begin
        blit_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still outstanding",
               cycles, planar_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // stimulus: directed phases, then random geometry phases
  // ------------------------------------------------------------------
  initial begin
    logic [c2p_pkg::CFG_DATA_W-1:0] w_data;
    logic [c2p_pkg::CFG_DATA_W-1:0] h_data;
    logic [c2p_pkg::CFG_DATA_W-1:0] s_data;
    int n;

    // every input known from time zero
    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = c2p_pkg::REG_ACTIVE_WIDTH;
    cfg_data            = '0;
    pixel_if.valid      = 1'b0;
    pixel_if.func       = c2p_pkg::FUNC_PIXEL;
    pixel_if.pixel_byte = '0;
    blit_if.ready       = 1'b0;
    idle_on             = 1'b1;

    // model state after reset
    width_reg  = c2p_pkg::WIDTH_RESET;
    height_reg = c2p_pkg::HEIGHT_RESET;
    stride_reg = c2p_pkg::STRIDE_RESET;
    col_cnt    = '0;
    row_cnt    = '0;
    plane_acc  = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: frame start with a junk byte, then one full group
    // with all-ones, all-zeros and high-nibble-only bytes
    @(negedge clk);
    push_item(c2p_pkg::FUNC_FRAME_START, 8'hFF);
    push_item(c2p_pkg::FUNC_PIXEL, 8'h0F);
    push_item(c2p_pkg::FUNC_PIXEL, 8'h00);
    push_item(c2p_pkg::FUNC_PIXEL, 8'hF5);
    push_item(c2p_pkg::FUNC_PIXEL, 8'h0A);
    push_item(c2p_pkg::FUNC_PIXEL, 8'hFF);
    push_item(c2p_pkg::FUNC_PIXEL, 8'h01);
    push_item(c2p_pkg::FUNC_PIXEL, 8'h08);
    push_item(c2p_pkg::FUNC_PIXEL, 8'hF0);
    wait_drained();

    // narrow window: partial group at the last used column, columns past
    // the width inside the stride, and a second row past the height
    set_geometry(16'd3, 16'd1, 16'd5);
    @(negedge clk);
    push_item(c2p_pkg::FUNC_FRAME_START, 8'h00);
    repeat (10) push_item(c2p_pkg::FUNC_PIXEL, 8'($urandom));
    wait_drained();

    // zero width converts nothing
    set_geometry(16'd0, 16'd350, 16'd640);
    @(negedge clk);
    repeat (3) push_item(c2p_pkg::FUNC_PIXEL, 8'($urandom));
    wait_drained();

    // random phases; counters carry over unless a frame start is sent, so a
    // new stride can land below the current column
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      w_data = c2p_pkg::CFG_DATA_W'($urandom);
      h_data = c2p_pkg::CFG_DATA_W'($urandom);
      s_data = c2p_pkg::CFG_DATA_W'($urandom_range(1, 48));
      w_data[c2p_pkg::WIDTH_W-1:0]  = ($urandom_range(0, 3) == 0) ?
                                      c2p_pkg::WIDTH_W'($urandom_range(641, 1023)) :
                                      c2p_pkg::WIDTH_W'($urandom_range(0, 40));
      h_data[c2p_pkg::HEIGHT_W-1:0] = ($urandom_range(0, 3) == 0) ?
                                      c2p_pkg::HEIGHT_W'($urandom_range(351, 511)) :
                                      c2p_pkg::HEIGHT_W'($urandom_range(0, 6));
      if ($urandom_range(0, 9) == 0)
        s_data = c2p_pkg::CFG_DATA_W'($urandom);
      n = $urandom_range(20, 36);
      case (ph)
        0: begin
          // all registers at their top codes: width and height saturate
          w_data = '1;
          h_data = '1;
          s_data = '1;
        end
        1: begin
          // one pixel per row: runs past the height and pins the row
          // counter at its ceiling instead of wrapping
          w_data[c2p_pkg::WIDTH_W-1:0] = 10'd1;
          h_data[c2p_pkg::HEIGHT_W-1:0] = 9'd511;
          s_data = 16'd1;
          n = LONG_RUN;
        end
        2: s_data = '0;
        3: w_data[c2p_pkg::WIDTH_W-1:0] = '0;
        4: h_data[c2p_pkg::HEIGHT_W-1:0] = '0;
        default: begin
        end
      endcase
      set_geometry(w_data, h_data, s_data);

      @(negedge clk);
      // quiet stretches mid-run, and none at all toward the end
      idle_on = (ph < RAND_PHASES - 2) && (ph % 4 != 3);
      if (ph <= 1 || $urandom_range(0, 1) == 0)
        push_item(c2p_pkg::FUNC_FRAME_START, 8'($urandom));
      repeat (n) begin
        // the long one-pixel-row run keeps going so the row counter saturates
        if (ph != 1 && $urandom_range(0, 99) < 4)
          push_item(c2p_pkg::FUNC_FRAME_START, 8'($urandom));
        else
          push_item(c2p_pkg::FUNC_PIXEL, 8'($urandom));
      end
      wait_drained();
    end

    // let anything late show up
    repeat (20) @(negedge clk);

    $display("%0d source transfers (%0d frame starts) under %0d geometry settings",
             items_taken, frame_starts, geometry_count);
    $display("%0d plane words compared, %0d failures", words_checked, fail_count);
    if (fail_count == 0 && planar_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
